>>> rtl/dmxhtp_pkg.sv
package dmxhtp_pkg;

  // field widths of one word
  localparam int unsigned CHAN_W = 10;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned PROD_W = 2 * LVL_W;

  // function codes
  localparam logic FUNC_MERGE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [PROD_W-1:0] prod_t;

  // truncating divide of a level*factor product by full scale (255);
  // exact for every product of two 8-bit values
  function automatic lvl_t div_full_scale(input prod_t p);
    logic [PROD_W:0] sum;
    begin
      sum = {1'b0, p} + {{(LVL_W+1){1'b0}}, p[PROD_W-1:LVL_W]} + {{PROD_W{1'b0}}, 1'b1};
      return sum[PROD_W-1:LVL_W];
    end
  endfunction

endpackage

>>> rtl/dmxhtp_in_if.sv
interface dmxhtp_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  dmxhtp_pkg::chan_t    channel;
  dmxhtp_pkg::lvl_t     level;
  dmxhtp_pkg::lvl_t     factor;

  modport source (output valid, func, channel, level, factor, input ready);
  modport sink   (input valid, func, channel, level, factor, output ready);
endinterface

>>> rtl/dmxhtp_out_if.sv
interface dmxhtp_out_if;
  logic                 valid;
  logic                 ready;
  dmxhtp_pkg::chan_t    slot_index;
  dmxhtp_pkg::lvl_t     slot_value;

  modport source (output valid, slot_index, slot_value, input ready);
  modport sink   (input valid, slot_index, slot_value, output ready);
endinterface

>>> rtl/dmx_htp_merge_buffer.sv
// DMX universe store with highest-takes-precedence merging.
// in_chan carries one word per item: func, channel, level, factor.
//   Merge (func 0): level*factor/255 replaces the slot byte if larger;
//   slots 0 and above CHANNELS are dropped. No result word.
//   Read (func 1): one result word on out_chan with slot_index and its
//   byte; the slot is then cleared. Slot 0 and slots above CHANNELS read 0.
// Valid/ready handshake on both channels; a word moves when both are high.
// Throughput: one item per cycle unless a stall or the reset sweep holds
// in_chan.ready low. The store read and stage 1 registers load at the
// accepting edge; the result register then loads once the pipeline advances.
// Same-slot items back to back are handled by forwarding the last update.
// Reset: the store is cleared by a sweep over all CHANNELS bytes, one byte a
// cycle; in_chan.ready stays low during the sweep.
// Stall: while a result waits on a low out_chan.ready, the pipeline holds
// and in_chan.ready is low; no word is lost or repeated.
module dmx_htp_merge_buffer #(
  parameter int unsigned CHANNELS = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  dmxhtp_in_if.sink     in_chan,
  dmxhtp_out_if.source  out_chan
);

  localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                 busy;
  logic                 advance;
  logic                 acc;
  logic                 in_range0;
  logic [ADDR_W-1:0]    addr0;
  dmxhtp_pkg::chan_t    chan_m1;
  dmxhtp_pkg::prod_t    prod0;
  dmxhtp_pkg::lvl_t     rd_data;
  dmxhtp_pkg::lvl_t     old_val;
  dmxhtp_pkg::lvl_t     new_val;
  logic                 wr_en;

  // stage 1 registers
  logic                 s1_valid_r;
  logic                 s1_func_r;
  dmxhtp_pkg::chan_t    s1_chan_r;
  dmxhtp_pkg::prod_t    s1_prod_r;
  logic                 s1_inr_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic                 s1_fwd_r;
  dmxhtp_pkg::lvl_t     s1_fwd_data_r;

  // result register
  logic                 out_valid_r;
  dmxhtp_pkg::chan_t    out_index_r;
  dmxhtp_pkg::lvl_t     out_value_r;

  // pipeline moves unless a result is stuck
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance && !busy;
  assign acc           = in_chan.valid && in_chan.ready;

  // stage 0: address decode and product
  assign in_range0 = (in_chan.channel != '0) &&
                     (in_chan.channel <= dmxhtp_pkg::CHAN_W'(CHANNELS));
  assign chan_m1   = in_chan.channel - 1'b1;
  assign addr0     = chan_m1[ADDR_W-1:0];
  assign prod0     = dmxhtp_pkg::PROD_W'(in_chan.level) * dmxhtp_pkg::PROD_W'(in_chan.factor);

  dmxhtp_store #(
    .DEPTH  (CHANNELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (addr0),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (new_val),
    .busy    (busy)
  );

  // stage 1: old byte with forwarding, then update
  always_comb begin
    if (!s1_inr_r) begin
      old_val = '0;
    end else if (s1_fwd_r) begin
      old_val = s1_fwd_data_r;
    end else begin
      old_val = rd_data;
    end
  end

  dmxhtp_update u_update (
    .func    (s1_func_r),
    .prod    (s1_prod_r),
    .old_val (old_val),
    .new_val (new_val)
  );

  assign wr_en = advance && s1_valid_r && s1_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_func_r     <= in_chan.func;
      s1_chan_r     <= in_chan.channel;
      s1_prod_r     <= prod0;
      s1_inr_r      <= in_range0;
      s1_addr_r     <= addr0;
      s1_fwd_r      <= wr_en && (s1_addr_r == addr0);
      s1_fwd_data_r <= new_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && (s1_func_r == dmxhtp_pkg::FUNC_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_index_r <= s1_chan_r;
      out_value_r <= old_val;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.slot_index = out_index_r;
  assign out_chan.slot_value = out_value_r;

endmodule

>>> rtl/dmxhtp_store.sv
module dmxhtp_store #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output dmxhtp_pkg::lvl_t         rd_data,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  dmxhtp_pkg::lvl_t         wr_data,
  output logic                     busy
);

  dmxhtp_pkg::lvl_t    mem [DEPTH];
  dmxhtp_pkg::lvl_t    rd_data_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [ADDR_W-1:0]   clr_cnt_nxt;
  logic                clearing_r;
  logic                clearing_nxt;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  dmxhtp_pkg::lvl_t    mem_wdata;

  // clear sweep after reset, one entry a cycle
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // write port shared by sweep and updates
  assign mem_we    = clearing_r | wr_en;
  assign mem_waddr = clearing_r ? clr_cnt_r : wr_addr;
  assign mem_wdata = clearing_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

>>> rtl/dmxhtp_update.sv
module dmxhtp_update (
  input  logic                 func,
  input  dmxhtp_pkg::prod_t    prod,
  input  dmxhtp_pkg::lvl_t     old_val,
  output dmxhtp_pkg::lvl_t     new_val
);

  dmxhtp_pkg::lvl_t scaled;

  // scale, then highest takes precedence; a read clears the slot
  always_comb begin
    scaled = dmxhtp_pkg::div_full_scale(prod);
    if (func == dmxhtp_pkg::FUNC_READ) begin
      new_val = '0;
    end else if (scaled > old_val) begin
      new_val = scaled;
    end else begin
      new_val = old_val;
    end
  end

endmodule
